// ===== hw/rtl/trs_pkg.sv =====
// Shared types and constants for the text region scroll block.
// Used by trs_front, trs_back, trs_fifo users and text_region_scroll_core.
`default_nettype none

package trs_pkg;

  // Coordinates inside an accepted region always stay below 256.
  localparam int unsigned COORD_W = 8;
  localparam int unsigned HCNT_W  = 7;
  localparam int unsigned WCNT_W  = 8;
  localparam int unsigned CMP_W   = 9;
  localparam int unsigned CELL_W  = 16;

  localparam logic [7:0] BLANK_CHAR = 8'h20;

  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_SCROLL = 2'd2;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NATIVE_ATTR = 1'b1;

  typedef struct packed {
    logic [1:0] req_type;
    logic [5:0] row;
    logic [6:0] col;
    logic [6:0] height;
    logic [7:0] width;
    logic [1:0] direction;
    logic [7:0] offset;
    logic [7:0] fill_attr;
    logic       use_native;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
  } trs_req_t;

  typedef struct packed {
    logic [7:0] read_char;
    logic [7:0] read_attr;
    logic       dirty;
    logic       status;
  } trs_rsp_t;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_READ,
    CMD_SCROLL,
    CMD_REJECT
  } trs_cmd_kind_e;

  // Classified work for the back end. For cell ops dr0/dc0 hold the cell.
  typedef struct packed {
    trs_cmd_kind_e      kind;
    logic [CELL_W-1:0]  data;
    logic               row_dec;
    logic               col_dec;
    logic [HCNT_W-1:0]  cp_rows;
    logic [WCNT_W-1:0]  cp_cols;
    logic [COORD_W-1:0] dr0;
    logic [COORD_W-1:0] dc0;
    logic [COORD_W-1:0] sr0;
    logic [COORD_W-1:0] sc0;
    logic [COORD_W-1:0] fr;
    logic [COORD_W-1:0] fc;
    logic [HCNT_W-1:0]  fh;
    logic [WCNT_W-1:0]  fw;
  } trs_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/trs_fifo.sv =====
// Small register FIFO used for the command queue and the result queue.
// Self-contained; no package dependency.
`default_nettype none

module trs_fifo #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PTR_W = $clog2(DEPTH),
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = store_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/trs_front.sv =====
// Front end: accepts request items, range-checks them and turns scrolls into
// copy and fill rectangles. Depends on trs_pkg.
`default_nettype none

module trs_front
  import trs_pkg::*;
#(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 128,
  localparam int unsigned PW = $clog2(MAX_COLS + 1)
) (
  input  wire logic          push_i,
  input  wire trs_req_t      req_i,
  output logic               full_o,
  input  wire logic [PW-1:0] pitch_i,
  input  wire logic [7:0]    native_attr_i,
  input  wire logic          cmd_full_i,
  output logic               cmd_push_o,
  output trs_cmd_t           cmd_o
);

  logic               cell_ok, region_ok, do_shift;
  logic [7:0]         extent, attr;
  logic [COORD_W-1:0] row8, col8, h8, w8, off8;

  assign full_o     = cmd_full_i;
  assign cmd_push_o = push_i && !cmd_full_i;

  assign row8 = COORD_W'(req_i.row);
  assign col8 = COORD_W'(req_i.col);
  assign h8   = COORD_W'(req_i.height);
  assign w8   = COORD_W'(req_i.width);
  assign off8 = req_i.offset;

  assign cell_ok = (CMP_W'(req_i.row) < CMP_W'(MAX_ROWS)) &&
                   (CMP_W'(req_i.col) < CMP_W'(pitch_i));
  assign region_ok = (CMP_W'(req_i.row) + CMP_W'(req_i.height) <= CMP_W'(MAX_ROWS)) &&
                     (CMP_W'(req_i.col) + CMP_W'(req_i.width) <= CMP_W'(pitch_i));

  assign attr     = req_i.use_native ? native_attr_i : req_i.fill_attr;
  assign extent   = (req_i.direction == DIR_UP || req_i.direction == DIR_DOWN) ? h8 : w8;
  // zero offset or one at or past the extent degrades to a plain clear
  assign do_shift = (req_i.offset != 8'd0) && (req_i.offset < extent);

  always_comb begin
    cmd_o      = '0;
    cmd_o.kind = CMD_REJECT;
    cmd_o.dr0  = row8;
    cmd_o.dc0  = col8;
    unique case (req_i.req_type)
      REQ_WRITE, REQ_READ: begin
        cmd_o.data = {req_i.cell_attr, req_i.cell_char};
        if (cell_ok) begin
          cmd_o.kind = (req_i.req_type == REQ_WRITE) ? CMD_WRITE : CMD_READ;
        end
      end
      REQ_SCROLL: begin
        cmd_o.data = {attr, BLANK_CHAR};
        cmd_o.fr   = row8;
        cmd_o.fc   = col8;
        cmd_o.fh   = req_i.height;
        cmd_o.fw   = req_i.width;
        if (region_ok) begin
          cmd_o.kind = CMD_SCROLL;
          if (do_shift) begin
            unique case (req_i.direction)
              DIR_UP: begin
                cmd_o.cp_rows = HCNT_W'(h8 - off8);
                cmd_o.cp_cols = req_i.width;
                cmd_o.sr0     = row8 + off8;
                cmd_o.sc0     = col8;
                cmd_o.fr      = row8 + h8 - off8;
                cmd_o.fh      = HCNT_W'(off8);
              end
              DIR_DOWN: begin
                cmd_o.cp_rows = HCNT_W'(h8 - off8);
                cmd_o.cp_cols = req_i.width;
                cmd_o.row_dec = 1'b1;
                cmd_o.dr0     = row8 + h8 - COORD_W'(1);
                cmd_o.sr0     = row8 + h8 - COORD_W'(1) - off8;
                cmd_o.sc0     = col8;
                cmd_o.fh      = HCNT_W'(off8);
              end
              DIR_LEFT: begin
                cmd_o.cp_rows = req_i.height;
                cmd_o.cp_cols = WCNT_W'(w8 - off8);
                cmd_o.sr0     = row8;
                cmd_o.sc0     = col8 + off8;
                cmd_o.fc      = col8 + w8 - off8;
                cmd_o.fw      = WCNT_W'(off8);
              end
              DIR_RIGHT: begin
                cmd_o.cp_rows = req_i.height;
                cmd_o.cp_cols = WCNT_W'(w8 - off8);
                cmd_o.col_dec = 1'b1;
                cmd_o.dc0     = col8 + w8 - COORD_W'(1);
                cmd_o.sr0     = row8;
                cmd_o.sc0     = col8 + w8 - COORD_W'(1) - off8;
                cmd_o.fw      = WCNT_W'(off8);
              end
              default: begin
                cmd_o.cp_rows = '0;
              end
            endcase
          end
        end
      end
      default: begin
        cmd_o.kind = CMD_REJECT;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/trs_back.sv =====
// Back end: executes classified commands on the cell memory, one cell per
// cycle, and produces one result per command. Depends on trs_pkg.
`default_nettype none

module trs_back
  import trs_pkg::*;
#(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 128,
  localparam int unsigned PW    = $clog2(MAX_COLS + 1),
  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned MULW  = COORD_W + PW + 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [PW-1:0] pitch_i,
  input  wire logic          cmd_empty_i,
  input  wire trs_cmd_t      cmd_i,
  output logic               cmd_pop_o,
  input  wire logic          res_full_i,
  output logic               res_push_o,
  output trs_rsp_t           res_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CELL,
    S_SRC,
    S_DST,
    S_COPY,
    S_FSET,
    S_FILL,
    S_DONE
  } state_e;

  state_e              state_q, state_d;
  trs_cmd_t            cmd_q, cmd_d;
  logic [HCNT_W-1:0]   i_q, i_d, rows_lim;
  logic [WCNT_W-1:0]   j_q, j_d, cols_lim;
  logic [AW-1:0]       s_row_q, s_row_d, s_addr_q, s_addr_d;
  logic [AW-1:0]       d_row_q, d_row_d, d_addr_q, d_addr_d;
  logic [AW-1:0]       dpend_q, dpend_d;
  logic                cpend_q, cpend_d;
  logic                dirty_q, dirty_d;
  logic [CELL_W-1:0]   rdata_q;
  logic [CELL_W-1:0]   mem [DEPTH];

  logic [COORD_W-1:0]  mul_r, mul_c;
  logic [MULW-1:0]     mul_full;
  logic [AW-1:0]       mul_addr, pstep, row_step_s, row_step_d;
  logic                last_col, last_row, rdec, cdec;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [CELL_W-1:0]   mem_wdata;
  logic                is_read;

  // one shared row*pitch+col unit for all start addresses
  always_comb begin
    unique case (state_q)
      S_SRC: begin
        mul_r = cmd_q.sr0;
        mul_c = cmd_q.sc0;
      end
      S_FSET: begin
        mul_r = cmd_q.fr;
        mul_c = cmd_q.fc;
      end
      default: begin
        mul_r = cmd_q.dr0;
        mul_c = cmd_q.dc0;
      end
    endcase
  end

  assign mul_full = MULW'(mul_r) * MULW'(pitch_i) + MULW'(mul_c);
  assign mul_addr = AW'(mul_full);
  assign pstep    = AW'(pitch_i);

  assign rows_lim = (state_q == S_COPY) ? cmd_q.cp_rows : cmd_q.fh;
  assign cols_lim = (state_q == S_COPY) ? cmd_q.cp_cols : cmd_q.fw;
  assign last_col = (j_q == cols_lim - WCNT_W'(1));
  assign last_row = (i_q == rows_lim - HCNT_W'(1));
  assign rdec     = (state_q == S_COPY) && cmd_q.row_dec;
  assign cdec     = (state_q == S_COPY) && cmd_q.col_dec;
  assign is_read  = (cmd_q.kind == CMD_READ);

  assign row_step_s = rdec ? s_row_q - pstep : s_row_q + pstep;
  assign row_step_d = rdec ? d_row_q - pstep : d_row_q + pstep;

  // Copy writes land in the cycle after their read; fills and cell writes never
  // overlap a pending copy write.
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = s_addr_q;
    mem_we    = 1'b0;
    mem_waddr = d_addr_q;
    mem_wdata = cmd_q.data;
    if (state_q == S_COPY) begin
      mem_re = 1'b1;
    end else if (state_q == S_CELL && is_read) begin
      mem_re    = 1'b1;
      mem_raddr = mul_addr;
    end
    if (cpend_q) begin
      mem_we    = 1'b1;
      mem_waddr = dpend_q;
      mem_wdata = rdata_q;
    end else if (state_q == S_FILL) begin
      mem_we = 1'b1;
    end else if (state_q == S_CELL && cmd_q.kind == CMD_WRITE) begin
      mem_we    = 1'b1;
      mem_waddr = mul_addr;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    i_d        = i_q;
    j_d        = j_q;
    s_row_d    = s_row_q;
    s_addr_d   = s_addr_q;
    d_row_d    = d_row_q;
    d_addr_d   = d_addr_q;
    dpend_d    = dpend_q;
    cpend_d    = 1'b0;
    dirty_d    = dirty_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o.read_char = is_read ? rdata_q[7:0] : 8'd0;
    res_o.read_attr = is_read ? rdata_q[15:8] : 8'd0;
    res_o.dirty     = dirty_q || (cmd_q.kind == CMD_SCROLL);
    res_o.status    = (cmd_q.kind == CMD_REJECT);

    unique case (state_q)
      S_IDLE: begin
        // one command in flight, so the result queue still has room at push
        if (!cmd_empty_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          unique case (cmd_i.kind)
            CMD_WRITE, CMD_READ: state_d = S_CELL;
            CMD_SCROLL:          state_d = S_SRC;
            CMD_REJECT:          state_d = S_DONE;
            default:             state_d = S_DONE;
          endcase
        end
      end
      S_CELL: begin
        state_d = S_DONE;
      end
      S_SRC: begin
        s_row_d  = mul_addr;
        s_addr_d = mul_addr;
        state_d  = S_DST;
      end
      S_DST: begin
        d_row_d  = mul_addr;
        d_addr_d = mul_addr;
        i_d      = '0;
        j_d      = '0;
        state_d  = (cmd_q.cp_rows != '0 && cmd_q.cp_cols != '0) ? S_COPY : S_FSET;
      end
      S_COPY, S_FILL: begin
        if (state_q == S_COPY) begin
          cpend_d = 1'b1;
          dpend_d = d_addr_q;
        end
        if (last_col) begin
          j_d      = '0;
          i_d      = i_q + HCNT_W'(1);
          s_row_d  = row_step_s;
          s_addr_d = row_step_s;
          d_row_d  = row_step_d;
          d_addr_d = row_step_d;
          if (last_row) begin
            state_d = (state_q == S_COPY) ? S_FSET : S_DONE;
          end
        end else begin
          j_d      = j_q + WCNT_W'(1);
          s_addr_d = cdec ? s_addr_q - AW'(1) : s_addr_q + AW'(1);
          d_addr_d = cdec ? d_addr_q - AW'(1) : d_addr_q + AW'(1);
        end
      end
      S_FSET: begin
        d_row_d  = mul_addr;
        d_addr_d = mul_addr;
        i_d      = '0;
        j_d      = '0;
        state_d  = (cmd_q.fh != '0 && cmd_q.fw != '0) ? S_FILL : S_DONE;
      end
      S_DONE: begin
        res_push_o = 1'b1;
        dirty_d    = res_o.dirty;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cpend_q <= 1'b0;
      dirty_q <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      cpend_q <= cpend_d;
      dirty_q <= dirty_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    s_row_q  <= s_row_d;
    s_addr_q <= s_addr_d;
    d_row_q  <= d_row_d;
    d_addr_q <= d_addr_d;
    dpend_q  <= dpend_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/text_region_scroll_core.sv =====
// Text cell buffer with region scroll: config registers, front end, command
// queue, back end and result queue. Depends on trs_pkg, trs_front, trs_back,
// trs_fifo.
//
// Usage:
//  - Requests enter like a queue write: req_i is taken when push is high and
//    full is low. Results leave like a queue read: rsp_o is valid while empty
//    is low and is taken when pop is high. Every request gives one result.
//  - Config (row pitch, native attribute) is written over cfg_valid_i /
//    cfg_ready_o; cfg_ready_o is always high. Write only while idle.
//  - After the command queue, a rejected item goes straight to the done
//    state, a cell write or read passes through the cell state, and a
//    scroll runs source and destination setup, the copy if any, fill setup,
//    the fill if any and the done state; the single cell-memory write port
//    moves one cell per cycle. The back end runs one item at a time and takes
//    the next item only after the last one's result is pushed.
//  - A two-entry command queue keeps accepting while the back end works,
//    and a two-entry result queue holds results while the receiver stalls;
//    a stalled receiver eventually backs up into full.
//  - Reset clears dirty, sets pitch 80 and native attribute 7. The cell
//    memory is not cleared; cells read before being written are undefined.
`default_nettype none

module text_region_scroll_core
  import trs_pkg::*;
#(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 128
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push,
  input  wire trs_req_t             req_i,
  output logic                      full,
  output logic                      empty,
  input  wire logic                 pop,
  output trs_rsp_t                  rsp_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [7:0]           cfg_data_i
);

  localparam int unsigned PW = $clog2(MAX_COLS + 1);

  logic [7:0]    row_pitch_q, row_pitch_d, native_attr_q, native_attr_d;
  logic [PW-1:0] pitch_eff;
  logic          cmd_full, cmd_push, cmd_pop, cmd_empty;
  trs_cmd_t      cmd_in, cmd_out;
  logic          res_push, res_full;
  trs_rsp_t      res;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    row_pitch_d   = row_pitch_q;
    native_attr_d = native_attr_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ROW_PITCH:   row_pitch_d   = cfg_data_i;
        CFG_NATIVE_ATTR: native_attr_d = cfg_data_i;
        default:         row_pitch_d   = row_pitch_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_pitch_q   <= 8'd80;
      native_attr_q <= 8'd7;
    end else begin
      row_pitch_q   <= row_pitch_d;
      native_attr_q <= native_attr_d;
    end
  end

  // zero pitch acts as one, oversize pitch clamps to the buffer width
  always_comb begin
    if (row_pitch_q == 8'd0) begin
      pitch_eff = PW'(1);
    end else if (CMP_W'(row_pitch_q) > CMP_W'(MAX_COLS)) begin
      pitch_eff = PW'(MAX_COLS);
    end else begin
      pitch_eff = PW'(row_pitch_q);
    end
  end

  trs_front #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_front (
    .push_i       (push),
    .req_i        (req_i),
    .full_o       (full),
    .pitch_i      (pitch_eff),
    .native_attr_i(native_attr_q),
    .cmd_full_i   (cmd_full),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd_in)
  );

  trs_fifo #(
    .WIDTH($bits(trs_cmd_t)),
    .DEPTH(2)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .wdata_i(cmd_in),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .rdata_o(cmd_out),
    .empty_o(cmd_empty)
  );

  trs_back #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pitch_i    (pitch_eff),
    .cmd_empty_i(cmd_empty),
    .cmd_i      (cmd_out),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res)
  );

  trs_fifo #(
    .WIDTH($bits(trs_rsp_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(rsp_o),
    .empty_o(empty)
  );

  a_res_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result pushed into a full result queue");

  a_cmd_avail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> !cmd_empty)
    else $error("command taken from an empty command queue");

  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && res.status) |-> (res.read_char == 8'd0 && res.read_attr == 8'd0))
    else $error("rejected item returned read data");

endmodule

`default_nettype wire

// ===== tb/tb_text_region_scroll_core.sv =====
// Self-checking bench for text_region_scroll_core: queued requests, popped results.
// Predicts every result from a local copy of the cell buffer and config registers.
// Depends on trs_pkg and text_region_scroll_core.

module tb_text_region_scroll_core;
  import trs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROWS     = 64;
  localparam int unsigned COLS     = 128;
  localparam int unsigned DEPTH    = ROWS * COLS;
  localparam int unsigned AW       = $clog2(DEPTH);
  localparam int unsigned HOLD_LEN = 1000;
  localparam logic [1:0]  REQ_UNUSED = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 push = 1'b0;
  trs_req_t             req = '0;
  logic                 full;
  logic                 empty;
  logic                 pop = 1'b0;
  trs_rsp_t             rsp;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;

  // local image of the block
  logic [15:0] cell_img [DEPTH];
  logic [7:0]  pitch_reg = 8'd80;
  logic [7:0]  native_reg = 8'd7;
  logic        scrolled = 1'b0;

  trs_req_t    req_pending_q [$];
  trs_rsp_t    expected_rsp_q [$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req = 1'b0;
  logic        rx_hold = 1'b0;
  int unsigned mismatches = 0;
  int unsigned rsp_cnt = 0;
  longint unsigned work_budget = 0;
  longint unsigned cycle_cnt = 0;

  text_region_scroll_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .req_i       (req),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .rsp_o       (rsp),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5ns clk_i = 1'b1;
    #5ns clk_i = 1'b0;
  end

  function automatic int unsigned stride();
    if (pitch_reg == 8'd0) return 1;
    if (32'(pitch_reg) > COLS) return COLS;
    return 32'(pitch_reg);
  endfunction

  function automatic logic [AW-1:0] cell_addr(int unsigned r, int unsigned c);
    return AW'((r * stride() + c) % DEPTH);
  endfunction

  function automatic void move_cell(int unsigned rd, int unsigned cd,
                                    int unsigned rs, int unsigned cs);
    cell_img[cell_addr(rd, cd)] = cell_img[cell_addr(rs, cs)];
  endfunction

  // Applies one request to the buffer image and returns its result.
  function automatic trs_rsp_t buffer_image_step(trs_req_t rq);
    trs_rsp_t    rs;
    int unsigned s, r0, c0, h, w, off, ext, fr, fh, fc, fw, r, c;
    logic [15:0] blank;
    rs = '0;
    rs.status = 1'b1;
    s = stride();
    r0 = 32'(rq.row);
    c0 = 32'(rq.col);
    h = 32'(rq.height);
    w = 32'(rq.width);
    off = 32'(rq.offset);
    case (rq.req_type)
      REQ_WRITE, REQ_READ: begin
        if (c0 < s) begin
          if (rq.req_type == REQ_WRITE) begin
            cell_img[cell_addr(r0, c0)] = {rq.cell_attr, rq.cell_char};
          end else begin
            {rs.read_attr, rs.read_char} = cell_img[cell_addr(r0, c0)];
          end
          rs.status = 1'b0;
        end
      end
      REQ_SCROLL: begin
        if (r0 + h <= ROWS && c0 + w <= s) begin
          blank = {rq.use_native ? native_reg : rq.fill_attr, BLANK_CHAR};
          ext = (rq.direction == DIR_UP || rq.direction == DIR_DOWN) ? h : w;
          fr = 0;
          fh = h;
          fc = 0;
          fw = w;
          // offset of zero or at/past the extent: whole region is blanked
          if (off != 0 && off < ext) begin
            case (rq.direction)
              DIR_UP: begin
                for (r = 0; r < h - off; r++)
                  for (c = 0; c < w; c++) move_cell(r0 + r, c0 + c, r0 + r + off, c0 + c);
                fr = h - off;
                fh = off;
              end
              DIR_DOWN: begin
                for (r = h; r > off; r--)
                  for (c = 0; c < w; c++)
                    move_cell(r0 + r - 1, c0 + c, r0 + r - 1 - off, c0 + c);
                fh = off;
              end
              DIR_LEFT: begin
                for (r = 0; r < h; r++)
                  for (c = 0; c < w - off; c++) move_cell(r0 + r, c0 + c, r0 + r, c0 + c + off);
                fc = w - off;
                fw = off;
              end
              default: begin
                for (r = 0; r < h; r++)
                  for (c = w; c > off; c--)
                    move_cell(r0 + r, c0 + c - 1, r0 + r, c0 + c - 1 - off);
                fw = off;
              end
            endcase
          end
          for (r = 0; r < fh; r++)
            for (c = 0; c < fw; c++) cell_img[cell_addr(r0 + fr + r, c0 + fc + c)] = blank;
          scrolled = 1'b1;
          rs.status = 1'b0;
        end
      end
      default: ;
    endcase
    rs.dirty = scrolled;
    return rs;
  endfunction

  function automatic trs_req_t cell_op(logic [1:0] kind, int unsigned r, int unsigned c,
                                       logic [7:0] ch, logic [7:0] at);
    trs_req_t rq;
    rq = '0;
    rq.req_type = kind;
    rq.row = 6'(r);
    rq.col = 7'(c);
    rq.cell_char = ch;
    rq.cell_attr = at;
    return rq;
  endfunction

  function automatic trs_req_t scroll_op(int unsigned r, int unsigned c, int unsigned h,
                                         int unsigned w, logic [1:0] dir, int unsigned off,
                                         logic [7:0] fill, logic native);
    trs_req_t rq;
    rq = '0;
    rq.req_type = REQ_SCROLL;
    rq.row = 6'(r);
    rq.col = 7'(c);
    rq.height = 7'(h);
    rq.width = 8'(w);
    rq.direction = dir;
    rq.offset = 8'(off);
    rq.fill_attr = fill;
    rq.use_native = native;
    return rq;
  endfunction

  // Mostly well-formed requests near the top-left corner, some noise and bad regions.
  function automatic trs_req_t random_item();
    trs_req_t    rq;
    logic [95:0] noise;
    int unsigned s, pick, h, w, ext;
    s = stride();
    noise = {$urandom, $urandom, $urandom};
    rq = noise[64:0];
    pick = $urandom_range(0, 99);
    if (pick < 8) return rq;
    if (pick < 62) begin
      rq.req_type = (pick < 38) ? REQ_WRITE : REQ_READ;
      if (s < COLS && $urandom_range(0, 9) == 0) begin
        rq.col = 7'($urandom_range(s, COLS - 1));
      end else if ($urandom_range(0, 2) != 0) begin
        rq.row = 6'($urandom_range(0, 15));
        rq.col = 7'($urandom_range(0, ((s < 24) ? s : 24) - 1));
      end else begin
        rq.col = 7'($urandom_range(0, s - 1));
      end
      return rq;
    end
    rq.req_type = REQ_SCROLL;
    if ($urandom_range(0, 9) == 0) begin
      h = $urandom_range(0, ROWS);
      w = $urandom_range(0, s);
    end else begin
      h = $urandom_range(0, 8);
      w = $urandom_range(0, (s < 16) ? s : 16);
    end
    rq.height = 7'(h);
    rq.width = 8'(w);
    if ($urandom_range(0, 9) == 0) begin
      // region runs off the bottom or the right edge
      if ($urandom_range(0, 1) == 1) begin
        rq.height = 7'($urandom_range(ROWS - 32'(rq.row) + 1, 127));
      end else if (32'(rq.col) < s) begin
        rq.width = 8'($urandom_range(s - 32'(rq.col) + 1, 255));
      end
    end else if ($urandom_range(0, 1) == 1) begin
      rq.row = 6'($urandom_range(0, (ROWS - h < 12) ? ROWS - h : 12));
      rq.col = 7'($urandom_range(0, (s - w < 12) ? s - w : 12));
    end else begin
      rq.row = 6'($urandom_range(0, ROWS - h));
      rq.col = 7'($urandom_range(0, s - w));
    end
    ext = (rq.direction == DIR_UP || rq.direction == DIR_DOWN) ?
          32'(rq.height) : 32'(rq.width);
    pick = $urandom_range(0, 9);
    if (pick == 0) rq.offset = '0;
    else if (pick == 1 || ext < 2) rq.offset = 8'($urandom_range(ext, 255));
    else rq.offset = 8'($urandom_range(1, ext - 1));
    return rq;
  endfunction

  task automatic add_item(trs_req_t rq);
    int unsigned cells;
    cells = 32'(rq.height) * 32'(rq.width);
    work_budget += 64 + ((cells > DEPTH) ? DEPTH : cells);
    req_pending_q.push_back(rq);
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (req_pending_q.size() != 0 || push || expected_rsp_q.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i);
    while (!cfg_ready);
    if (idx == CFG_ROW_PITCH) pitch_reg = val;
    else native_reg = val;
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_phase(logic [7:0] pitch, logic [7:0] native, int unsigned idle,
                           int unsigned stall, bit hold, int unsigned n);
    wait_idle();
    set_reg(CFG_ROW_PITCH, pitch);
    set_reg(CFG_NATIVE_ATTR, native);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    if (hold) begin
      work_budget += HOLD_LEN;
      hold_req = 1'b1;
    end
    repeat (n) add_item(random_item());
    wait_idle();
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d field %s: expected %0h, got %0h", rsp_cnt, name, want, got);
    end
  endtask

  // sender: offers pending items, predicts each one as it is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) expected_rsp_q.push_back(buffer_image_step(req));
      if (!push || !full) begin
        if (req_pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          req  <= req_pending_q.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // receiver: pops results and compares them with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_rsp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result %0d arrived with none predicted", rsp_cnt);
        end else begin
          trs_rsp_t want;
          want = expected_rsp_q.pop_front();
          check_field("read_char", rsp.read_char, want.read_char);
          check_field("read_attr", rsp.read_attr, want.read_attr);
          check_field("dirty", 8'(rsp.dirty), 8'(want.dirty));
          check_field("status", 8'(rsp.status), 8'(want.status));
        end
        rsp_cnt++;
      end
      pop <= !rx_hold && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // long receiver stall so the queues fill and full rises
  always begin
    wait (hold_req);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk_i);
    rx_hold <= 1'b0;
    hold_req = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 4 * work_budget + 50000) begin
      $display("tb_text_region_scroll_core: errors");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config: pitch 80, native attribute 7, dirty still clear
    add_item(cell_op(REQ_WRITE, 0, 0, 8'hFF, 8'hFF));
    add_item(cell_op(REQ_READ, 0, 0, 8'h00, 8'h00));
    add_item(cell_op(REQ_WRITE, 5, 80, 8'h12, 8'h34));
    add_item(cell_op(REQ_READ, 63, 127, 8'h00, 8'h00));
    add_item(scroll_op(60, 0, 8, 4, DIR_UP, 1, 8'h00, 1'b0));
    add_item(cell_op(REQ_UNUSED, 1, 1, 8'h55, 8'hAA));
    add_item(scroll_op(0, 0, ROWS, 80, DIR_UP, 0, 8'h00, 1'b1));
    add_item(cell_op(REQ_READ, 63, 79, 8'h00, 8'h00));
    wait_idle();

    set_reg(CFG_ROW_PITCH, 8'd128);
    set_reg(CFG_NATIVE_ATTR, 8'hA5);
    // blank the whole buffer so every later read sees defined cells
    add_item(scroll_op(0, 0, ROWS, COLS, DIR_RIGHT, 0, 8'h3C, 1'b0));
    add_item(cell_op(REQ_WRITE, 63, 127, 8'h00, 8'h00));
    add_item(cell_op(REQ_READ, 63, 127, 8'h00, 8'h00));
    add_item(cell_op(REQ_WRITE, 10, 10, 8'h41, 8'h01));
    add_item(cell_op(REQ_WRITE, 10, 11, 8'h42, 8'h02));
    add_item(cell_op(REQ_WRITE, 11, 10, 8'h43, 8'h03));
    add_item(cell_op(REQ_WRITE, 12, 13, 8'h44, 8'h04));
    add_item(scroll_op(10, 10, 4, 4, DIR_UP, 1, 8'h00, 1'b1));
    add_item(scroll_op(10, 10, 4, 4, DIR_DOWN, 2, 8'h11, 1'b0));
    add_item(scroll_op(10, 10, 4, 4, DIR_LEFT, 1, 8'h22, 1'b0));
    add_item(scroll_op(10, 10, 4, 4, DIR_RIGHT, 3, 8'h33, 1'b1));
    add_item(scroll_op(9, 9, 6, 6, DIR_UP, 6, 8'h44, 1'b0));
    add_item(scroll_op(8, 8, 8, 8, DIR_LEFT, 255, 8'h55, 1'b0));
    add_item(scroll_op(20, 20, 0, 5, DIR_DOWN, 1, 8'h66, 1'b0));
    add_item(scroll_op(63, 127, 1, 0, DIR_RIGHT, 0, 8'h77, 1'b0));
    add_item(scroll_op(0, 100, 2, 29, DIR_LEFT, 1, 8'h88, 1'b0));
    add_item(cell_op(REQ_READ, 10, 12, 8'h00, 8'h00));

    run_phase(8'd128, 8'h00, 0, 0, 1'b0, 14);
    run_phase(8'd1, 8'hFF, 59, 0, 1'b0, 12);
    run_phase(8'd0, 8'($urandom), 0, 59, 1'b0, 12);
    run_phase(8'd255, 8'($urandom), 22, 22, 1'b0, 12);
    run_phase(8'd80, 8'($urandom), 0, 0, 1'b1, 12);
    run_phase(8'($urandom_range(2, 127)), 8'($urandom), 22, 22, 1'b0, 12);

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_rsp_q.size() == 0) begin
      $display("tb_text_region_scroll_core: clean");
    end else begin
      $display("tb_text_region_scroll_core: errors");
    end
    $finish;
  end

endmodule
